[src/prz_pkg.sv]
package prz_pkg;

  localparam int MAX_SYMBOLS_DEF  = 8;
  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int PRICE_BITS       = 32;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 24;

  localparam logic [CFG_AW-1:0] CFG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_SYMBOL_COUNT   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_Z_THRESHOLD    = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_ORDER_QUANTITY = 2'd3;

  localparam logic [6:0]  WINDOW_LENGTH_RST  = 7'd20;
  localparam logic [3:0]  SYMBOL_COUNT_RST   = 4'd8;
  localparam logic [23:0] Z_THRESHOLD_RST    = 24'd131072;
  localparam logic [15:0] ORDER_QUANTITY_RST = 16'd100;

  localparam logic [31:0] RATIO_MAX = 32'hFFFF_FFFF;
  localparam logic [22:0] Z_MAX     = 23'h7F_FFFF;
  localparam logic [16:0] CONF_ONE  = 17'h1_0000;

  localparam int DIV_DW = 64;
  localparam int DIV_VW = 32;
  localparam int DIV_CW = 7;

  localparam logic [DIV_CW-1:0] DIV_STEPS_RATIO = 7'd48;
  localparam logic [DIV_CW-1:0] DIV_STEPS_WIDE  = 7'd64;
  localparam logic [DIV_CW-1:0] DIV_STEPS_CONF  = 7'd39;

  typedef struct packed {
    logic [3:0]            symbol_index;
    logic                  has_mid;
    logic [PRICE_BITS-1:0] mid_ticks;
    logic [63:0]           time_stamp;
  } in_beat_t;

  typedef struct packed {
    logic                  side;
    logic [3:0]            signal_symbol;
    logic [PRICE_BITS-1:0] signal_price;
    logic [15:0]           signal_quantity;
    logic [16:0]           confidence;
    logic [63:0]           signal_time;
    logic                  last_signal;
  } out_beat_t;

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] steps;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAIR,
    ST_RD1,
    ST_R1,
    ST_DIVR,
    ST_MEAN,
    ST_RD2,
    ST_MUL,
    ST_ACC,
    ST_VAR,
    ST_SQRT,
    ST_ZDIV,
    ST_CONF,
    ST_EMIT,
    ST_FINAL
  } state_t;

endpackage

[src/prz_div.sv]
module prz_div (
  input  logic               clk,
  input  logic               rst_n,
  input  prz_pkg::div_req_t  req,
  output prz_pkg::div_rsp_t  rsp
);
  import prz_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW-1:0] dvd_r;
  logic [DIV_VW-1:0] dsr_r;
  logic [DIV_VW-1:0] rem_r;
  logic [DIV_DW-1:0] quo_r;

  logic [$clog2(DIV_DW)-1:0] bit_idx;
  logic [DIV_VW:0]           trial;
  logic                      ge;
  logic [DIV_VW-1:0]         rem_nxt;
  logic [DIV_DW-1:0]         quo_nxt;
  logic [DIV_VW:0]           dif;

  always_comb begin
    bit_idx = $clog2(DIV_DW)'(cnt_r - DIV_CW'(1));
    trial   = {rem_r, dvd_r[bit_idx]};
    ge      = trial >= {1'b0, dsr_r};
    dif     = trial - {1'b0, dsr_r};
    rem_nxt = ge ? dif[DIV_VW-1:0] : trial[DIV_VW-1:0];
    quo_nxt = {quo_r[DIV_DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - DIV_CW'(1);
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[src/prz_sqrt.sv]
module prz_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  prz_pkg::sqrt_req_t  req,
  output prz_pkg::sqrt_rsp_t  rsp
);
  import prz_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [63:0] x_r;
  logic [63:0] res_r;
  logic [63:0] one_r;

  logic [64:0] trial;
  logic        ge;
  logic [64:0] x_dif;

  always_comb begin
    trial = {1'b0, res_r} + {1'b0, one_r};
    ge    = {1'b0, x_r} >= trial;
    x_dif = {1'b0, x_r} - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        x_r    <= req.radicand;
        res_r  <= '0;
        one_r  <= 64'h4000_0000_0000_0000;
      end else if (busy_r) begin
        if (ge) begin
          x_r   <= x_dif[63:0];
          res_r <= (res_r >> 1) + one_r;
        end else begin
          res_r <= res_r >> 1;
        end
        one_r <= one_r >> 2;
        if (one_r == 64'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[31:0];

endmodule

[src/pair_ratio_zscore_signal_unit.sv]
// An update that fills its window walks each partner with n common samples (a 48-step ratio
// division per sample unless the ratio saturates; 64-step mean and variance divisions,
// a 32-step root, 48-step z and 39-step confidence divisions per pair), and then waits for
// room at the output for each signal. One update at a time, bounded by the
// shared divider. Reset (synchronous, rst_n low) restores the default registers and empties
// every window; the price memory itself is not cleared.
module pair_ratio_zscore_signal_unit #(
  parameter int MAX_SYMBOLS  = prz_pkg::MAX_SYMBOLS_DEF,
  parameter int WINDOW_DEPTH = prz_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  prz_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output prz_pkg::out_beat_t             out_data,
  input  logic                           cfg_we,
  input  logic [prz_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [prz_pkg::CFG_DW-1:0]     cfg_wdata
);
  import prz_pkg::*;

  localparam int SYW  = $clog2(MAX_SYMBOLS);
  localparam int JW   = $clog2(MAX_SYMBOLS + 1);
  localparam int SW   = $clog2(WINDOW_DEPTH);
  localparam int FW   = $clog2(WINDOW_DEPTH + 1);
  localparam int AW   = $clog2(MAX_SYMBOLS * WINDOW_DEPTH);
  localparam int SUMW = 32 + FW;
  localparam int ACCW = 48 + FW;

  // configuration
  logic [6:0]  cfg_wl_r;
  logic [3:0]  cfg_sc_r;
  logic [23:0] cfg_thr_r;
  logic [15:0] cfg_qty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_wl_r  <= WINDOW_LENGTH_RST;
      cfg_sc_r  <= SYMBOL_COUNT_RST;
      cfg_thr_r <= Z_THRESHOLD_RST;
      cfg_qty_r <= ORDER_QUANTITY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WINDOW_LENGTH:  cfg_wl_r  <= cfg_wdata[6:0];
        CFG_SYMBOL_COUNT:   cfg_sc_r  <= cfg_wdata[3:0];
        CFG_Z_THRESHOLD:    cfg_thr_r <= cfg_wdata[23:0];
        CFG_ORDER_QUANTITY: cfg_qty_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic [JW-1:0] cnt_eff;
  logic [FW-1:0] len_eff;

  always_comb begin
    if (32'(cfg_sc_r) > MAX_SYMBOLS) cnt_eff = JW'(MAX_SYMBOLS);
    else                             cnt_eff = JW'(cfg_sc_r);
    if (cfg_wl_r == 7'd0)                  len_eff = FW'(1);
    else if (32'(cfg_wl_r) > WINDOW_DEPTH) len_eff = FW'(WINDOW_DEPTH);
    else                                   len_eff = FW'(cfg_wl_r);
  end

  // state
  state_t state_r, state_nxt;

  logic [FW-1:0] fill_lvl_r [MAX_SYMBOLS];
  logic [SW-1:0] wr_slot_r  [MAX_SYMBOLS];

  logic [PRICE_BITS-1:0] price_mem [MAX_SYMBOLS*WINDOW_DEPTH];
  logic [31:0]           ratio_mem [WINDOW_DEPTH];
  logic [PRICE_BITS-1:0] rda_r, rdb_r;
  logic [31:0]           sc_rd_r;

  logic [3:0]            sym_r, sym_nxt;
  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic [63:0]           stamp_r, stamp_nxt;
  logic [FW-1:0]         sfill_r, sfill_nxt;
  logic [SW-1:0]         sslot_r, sslot_nxt;
  logic [JW-1:0]         j_r, j_nxt;
  logic [FW-1:0]         n_r, n_nxt;
  logic [FW-1:0]         i_r, i_nxt;
  logic [SW-1:0]         pa_r, pa_nxt;
  logic [SW-1:0]         pb_r, pb_nxt;
  logic [SUMW-1:0]       sum_r, sum_nxt;
  logic [31:0]           mean_r, mean_nxt;
  logic [ACCW-1:0]       acc_r, acc_nxt;
  logic [31:0]           newest_r, newest_nxt;
  logic                  neg_r, neg_nxt;
  logic [63:0]           prod_r, prod_nxt;
  logic [16:0]           conf_r, conf_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  out_beat_t             pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_r, out_nxt;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  prz_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  prz_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  // combinational
  logic            accept;
  logic            tracked;
  logic [SYW-1:0]  in_sym;
  logic [SYW-1:0]  rd_idx;
  logic [FW-1:0]   rd_fill;
  logic [SW-1:0]   rd_slot;
  logic [FW:0]     fill_inc;
  logic [FW-1:0]   fill_new;
  logic [SW-1:0]   slot_new;
  logic            win_we;
  logic [AW-1:0]   win_waddr;
  logic [AW-1:0]   rd_addr_a, rd_addr_b;
  logic            sat;
  logic            store_now;
  logic [31:0]     ratio_v;
  logic            sc_we;
  logic [FW-1:0]   i_inc;
  logic [FW-1:0]   n_pair;
  logic [31:0]     d_abs;
  logic [31:0]     z_mag;
  logic [22:0]     z_sat;
  logic            out_free;
  out_beat_t       res_beat;

  function automatic logic [SW-1:0] ptr_dec(input logic [SW-1:0] p);
    ptr_dec = (p == '0) ? SW'(WINDOW_DEPTH - 1) : p - SW'(1);
  endfunction

  function automatic logic [AW-1:0] win_addr(input logic [SYW-1:0] s,
                                             input logic [SW-1:0] p);
    win_addr = AW'(AW'(s) * AW'(WINDOW_DEPTH)) + AW'(p);
  endfunction

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    accept    = in_valid && !in_stall;
    tracked   = in_data.has_mid && (32'(in_data.symbol_index) < 32'(cnt_eff));
    in_sym    = SYW'(in_data.symbol_index);
    rd_idx    = (state_r == ST_IDLE) ? in_sym : SYW'(j_r);
    rd_fill   = fill_lvl_r[rd_idx];
    rd_slot   = wr_slot_r[rd_idx];
    fill_inc  = {1'b0, rd_fill} + (FW+1)'(1);
    fill_new  = (fill_inc > {1'b0, len_eff}) ? len_eff : fill_inc[FW-1:0];
    slot_new  = (rd_slot == SW'(WINDOW_DEPTH - 1)) ? '0 : rd_slot + SW'(1);
    win_we    = accept && tracked;
    win_waddr = win_addr(in_sym, rd_slot);
    rd_addr_a = win_addr(SYW'(sym_r), pa_r);
    rd_addr_b = win_addr(SYW'(j_r), pb_r);
    n_pair    = (sfill_r < rd_fill) ? sfill_r : rd_fill;
    i_inc     = i_r + FW'(1);
    sat       = rdb_r <= {16'd0, rda_r[31:16]};
    store_now = ((state_r == ST_R1) && sat) || ((state_r == ST_DIVR) && div_rsp.done);
    ratio_v   = (state_r == ST_R1) ? RATIO_MAX : div_rsp.quotient[31:0];
    d_abs     = (sc_rd_r >= mean_r) ? sc_rd_r - mean_r : mean_r - sc_rd_r;
    z_mag     = (newest_r < mean_r) ? mean_r - newest_r : newest_r - mean_r;
    z_sat     = (div_rsp.quotient > 64'(Z_MAX)) ? Z_MAX : div_rsp.quotient[22:0];
    out_free  = !out_valid_r || !out_stall;

    res_beat.side            = !neg_r;
    res_beat.signal_symbol   = sym_r;
    res_beat.signal_price    = price_r;
    res_beat.signal_quantity = cfg_qty_r;
    res_beat.confidence      = conf_r;
    res_beat.signal_time     = stamp_r;
    res_beat.last_signal     = 1'b0;

    state_nxt      = state_r;
    sym_nxt        = sym_r;
    price_nxt      = price_r;
    stamp_nxt      = stamp_r;
    sfill_nxt      = sfill_r;
    sslot_nxt      = sslot_r;
    j_nxt          = j_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    pa_nxt         = pa_r;
    pb_nxt         = pb_r;
    sum_nxt        = sum_r;
    mean_nxt       = mean_r;
    acc_nxt        = acc_r;
    newest_nxt     = newest_r;
    neg_nxt        = neg_r;
    prod_nxt       = prod_r;
    conf_nxt       = conf_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_nxt        = out_r;
    out_valid_nxt  = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    sc_we          = 1'b0;
    div_req        = '0;
    sqrt_req       = '0;

    case (state_r)
      ST_IDLE: begin
        if (win_we) begin
          sym_nxt   = in_data.symbol_index;
          price_nxt = in_data.mid_ticks;
          stamp_nxt = in_data.time_stamp;
          sfill_nxt = fill_new;
          sslot_nxt = slot_new;
          j_nxt     = '0;
          if (fill_new == len_eff) state_nxt = ST_PAIR;
        end
      end
      ST_PAIR: begin
        if (j_r >= cnt_eff) begin
          state_nxt = ST_FINAL;
        end else if (j_r == JW'(sym_r) || n_pair < FW'(2)) begin
          j_nxt = j_r + JW'(1);
        end else begin
          n_nxt     = n_pair;
          i_nxt     = '0;
          sum_nxt   = '0;
          pa_nxt    = ptr_dec(sslot_r);
          pb_nxt    = ptr_dec(rd_slot);
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: state_nxt = ST_R1;
      ST_R1, ST_DIVR: begin
        if (state_r == ST_R1 && !sat) begin
          div_req.start    = 1'b1;
          div_req.steps    = DIV_STEPS_RATIO;
          div_req.dividend = {16'd0, rda_r, 16'd0};
          div_req.divisor  = rdb_r;
          state_nxt        = ST_DIVR;
        end
        if (store_now) begin
          sc_we   = 1'b1;
          sum_nxt = sum_r + SUMW'(ratio_v);
          if (i_r == '0) newest_nxt = ratio_v;
          i_nxt  = i_inc;
          pa_nxt = ptr_dec(pa_r);
          pb_nxt = ptr_dec(pb_r);
          if (i_inc == n_r) begin
            div_req.start    = 1'b1;
            div_req.steps    = DIV_STEPS_WIDE;
            div_req.dividend = DIV_DW'(sum_nxt);
            div_req.divisor  = DIV_VW'(n_r);
            state_nxt        = ST_MEAN;
          end else begin
            state_nxt = ST_RD1;
          end
        end
      end
      ST_MEAN: begin
        if (div_rsp.done) begin
          mean_nxt  = div_rsp.quotient[31:0];
          i_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_RD2;
        end
      end
      ST_RD2: state_nxt = ST_MUL;
      ST_MUL: begin
        prod_nxt  = 64'(d_abs) * 64'(d_abs);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = acc_r + ACCW'(prod_r[63:16]);
        i_nxt   = i_inc;
        if (i_inc == n_r) begin
          div_req.start    = 1'b1;
          div_req.steps    = DIV_STEPS_WIDE;
          div_req.dividend = DIV_DW'(acc_nxt);
          div_req.divisor  = DIV_VW'(n_r);
          state_nxt        = ST_VAR;
        end else begin
          state_nxt = ST_RD2;
        end
      end
      ST_VAR: begin
        if (div_rsp.done) begin
          sqrt_req.start    = 1'b1;
          sqrt_req.radicand = {div_rsp.quotient[47:0], 16'd0};
          state_nxt         = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_rsp.done) begin
          if (sqrt_rsp.root == '0) begin
            j_nxt     = j_r + JW'(1);
            state_nxt = ST_PAIR;
          end else begin
            neg_nxt          = newest_r < mean_r;
            div_req.start    = 1'b1;
            div_req.steps    = DIV_STEPS_RATIO;
            div_req.dividend = {16'd0, z_mag, 16'd0};
            div_req.divisor  = sqrt_rsp.root;
            state_nxt        = ST_ZDIV;
          end
        end
      end
      ST_ZDIV: begin
        if (div_rsp.done) begin
          if ({1'b0, z_sat} > cfg_thr_r) begin
            if (cfg_thr_r == '0) begin
              conf_nxt  = CONF_ONE;
              state_nxt = ST_EMIT;
            end else begin
              div_req.start    = 1'b1;
              div_req.steps    = DIV_STEPS_CONF;
              div_req.dividend = {25'd0, z_sat, 16'd0};
              div_req.divisor  = {7'd0, cfg_thr_r, 1'b0};
              state_nxt        = ST_CONF;
            end
          end else begin
            j_nxt     = j_r + JW'(1);
            state_nxt = ST_PAIR;
          end
        end
      end
      ST_CONF: begin
        if (div_rsp.done) begin
          conf_nxt  = (div_rsp.quotient > 64'(CONF_ONE)) ? CONF_ONE
                                                         : div_rsp.quotient[16:0];
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!pend_valid_r) begin
          pend_valid_nxt = 1'b1;
          pend_nxt       = res_beat;
          j_nxt          = j_r + JW'(1);
          state_nxt      = ST_PAIR;
        end else if (out_free) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          pend_nxt      = res_beat;
          j_nxt         = j_r + JW'(1);
          state_nxt     = ST_PAIR;
        end
      end
      ST_FINAL: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_nxt             = pend_r;
          out_nxt.last_signal = 1'b1;
          out_valid_nxt       = 1'b1;
          pend_valid_nxt      = 1'b0;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (win_we) price_mem[win_waddr] <= in_data.mid_ticks;
    if (state_r == ST_RD1) begin
      rda_r <= price_mem[rd_addr_a];
      rdb_r <= price_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (sc_we) ratio_mem[i_r[SW-1:0]] <= ratio_v;
    if (state_r == ST_RD2) sc_rd_r <= ratio_mem[i_r[SW-1:0]];
  end

  // per-symbol fill and write slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < MAX_SYMBOLS; s++) begin
        fill_lvl_r[s] <= '0;
        wr_slot_r[s]  <= '0;
      end
    end else if (win_we) begin
      fill_lvl_r[in_sym] <= fill_new;
      wr_slot_r[in_sym]  <= slot_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r    <= sym_nxt;
    price_r  <= price_nxt;
    stamp_r  <= stamp_nxt;
    sfill_r  <= sfill_nxt;
    sslot_r  <= sslot_nxt;
    j_r      <= j_nxt;
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    pa_r     <= pa_nxt;
    pb_r     <= pb_nxt;
    sum_r    <= sum_nxt;
    mean_r   <= mean_nxt;
    acc_r    <= acc_nxt;
    newest_r <= newest_nxt;
    neg_r    <= neg_nxt;
    prod_r   <= prod_nxt;
    conf_r   <= conf_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_pend_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_valid_r)
    else $error("pending beat left when idle");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIVR || state_r == ST_MEAN || state_r == ST_VAR ||
                      state_r == ST_ZDIV || state_r == ST_CONF))
    else $error("divider result outside a wait state");

  a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_rsp.done |-> state_r == ST_SQRT)
    else $error("root result outside its wait state");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD1 || state_r == ST_RD2) |-> (i_r < n_r && n_r >= FW'(2)))
    else $error("window walk out of range");

endmodule

[verif/tb_pair_ratio_zscore_signal_unit.sv]
`timescale 1ns / 100ps

module tb_pair_ratio_zscore_signal_unit;
  import prz_pkg::*;

  localparam int NSYM = MAX_SYMBOLS_DEF;
  localparam int DEPTH = WINDOW_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 5_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  pair_ratio_zscore_signal_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // shadow of block state and registers
  longint unsigned price_hist[NSYM][DEPTH];
  int unsigned fill_cnt[NSYM];
  int unsigned slot_ptr[NSYM];
  int unsigned win_reg = WINDOW_LENGTH_RST;
  int unsigned cnt_reg = SYMBOL_COUNT_RST;
  longint unsigned thr_reg = Z_THRESHOLD_RST;
  logic [15:0] qty_reg = ORDER_QUANTITY_RST;

  out_beat_t pending_signals[$];
  int unsigned base_px[NSYM];
  int errors = 0;
  int updates_sent = 0;
  int updates_ignored = 0;
  int signals_seen = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;

  function automatic longint unsigned ratio_fixed(longint unsigned num, longint unsigned den);
    if (den == 0) return {32'd0, RATIO_MAX};
    if (num / den >= 65536) return {32'd0, RATIO_MAX};
    return (num << 16) / den;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned hist_at(int s, int unsigned age);
    int unsigned idx;
    idx = slot_ptr[s] + DEPTH - 1 - age;
    if (idx >= DEPTH) idx -= DEPTH;
    return price_hist[s][idx];
  endfunction

  function automatic longint pair_zscore(int a, int b);
    int unsigned n;
    longint unsigned sum, mean, acc, r, d, sd, newest, mag;
    bit neg;
    n = fill_cnt[a] < fill_cnt[b] ? fill_cnt[a] : fill_cnt[b];
    if (n < 2) return 0;
    sum = 0;
    for (int i = 0; i < n; i++) sum += ratio_fixed(hist_at(a, i), hist_at(b, i));
    mean = sum / n;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      r = ratio_fixed(hist_at(a, i), hist_at(b, i));
      d = r >= mean ? r - mean : mean - r;
      acc += (d * d) >> 16;
    end
    sd = root_floor((acc / n) << 16);
    if (sd == 0) return 0;
    newest = ratio_fixed(hist_at(a, 0), hist_at(b, 0));
    neg = newest < mean;
    mag = neg ? mean - newest : newest - mean;
    mag = (mag << 16) / sd;
    if (mag > Z_MAX) mag = Z_MAX;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic int unsigned eff_count();
    return cnt_reg > NSYM ? NSYM : cnt_reg;
  endfunction

  function automatic int unsigned eff_window();
    return win_reg == 0 ? 1 : (win_reg > DEPTH ? DEPTH : win_reg);
  endfunction

  task automatic predict_update(in_beat_t b);
    int unsigned cnt, len, s, k;
    longint z;
    longint unsigned mag, conf;
    out_beat_t sig;
    cnt = eff_count();
    len = eff_window();
    s = b.symbol_index;
    updates_sent++;
    if (!b.has_mid || s >= cnt) begin
      updates_ignored++;
      return;
    end
    price_hist[s][slot_ptr[s]] = b.mid_ticks;
    slot_ptr[s] = slot_ptr[s] + 1 >= DEPTH ? 0 : slot_ptr[s] + 1;
    fill_cnt[s] = fill_cnt[s] + 1 > len ? len : fill_cnt[s] + 1;
    if (fill_cnt[s] < len) return;
    k = 0;
    for (int j = 0; j < cnt; j++) begin
      if (j == s) continue;
      z = pair_zscore(s, j);
      mag = z < 0 ? longint'(-z) : longint'(z);
      if (mag <= thr_reg) continue;
      if (thr_reg == 0) conf = CONF_ONE;
      else begin
        conf = (mag << 16) / (2 * thr_reg);
        if (conf > CONF_ONE) conf = CONF_ONE;
      end
      sig.side = z > 0;
      sig.signal_symbol = s[3:0];
      sig.signal_price = b.mid_ticks;
      sig.signal_quantity = qty_reg;
      sig.confidence = conf[16:0];
      sig.signal_time = b.time_stamp;
      sig.last_signal = 1'b0;
      pending_signals.insert(pending_signals.size(), sig);
      k++;
    end
    if (k > 0) pending_signals[pending_signals.size()-1].last_signal = 1'b1;
  endtask

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      signals_seen++;
      if (pending_signals.size() == 0) begin
        $error("unexpected signal beat: %p", out_data);
        errors++;
      end else begin
        want = pending_signals.pop_front();
        if (out_data.side !== want.side) begin
          $error("side: expected %0d, got %0d", want.side, out_data.side);
          errors++;
        end
        if (out_data.signal_symbol !== want.signal_symbol) begin
          $error("signal_symbol: expected %0d, got %0d", want.signal_symbol,
                 out_data.signal_symbol);
          errors++;
        end
        if (out_data.signal_price !== want.signal_price) begin
          $error("signal_price: expected %0h, got %0h", want.signal_price,
                 out_data.signal_price);
          errors++;
        end
        if (out_data.signal_quantity !== want.signal_quantity) begin
          $error("signal_quantity: expected %0d, got %0d", want.signal_quantity,
                 out_data.signal_quantity);
          errors++;
        end
        if (out_data.confidence !== want.confidence) begin
          $error("confidence: expected %0d, got %0d", want.confidence, out_data.confidence);
          errors++;
        end
        if (out_data.signal_time !== want.signal_time) begin
          $error("signal_time: expected %0h, got %0h", want.signal_time, out_data.signal_time);
          errors++;
        end
        if (out_data.last_signal !== want.last_signal) begin
          $error("last_signal: expected %0d, got %0d", want.last_signal, out_data.last_signal);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : sink_stall
    int left;
    if (left > 0) begin
      left--;
      out_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 6) == 0) begin
      left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_pair_ratio_zscore_signal_unit: errors");
      $finish;
    end
  end

  task automatic push_update(in_beat_t b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    predict_update(b);
  endtask

  task automatic tick(logic [3:0] sym, logic [31:0] px, logic [63:0] ts = 64'd0,
                      logic mid = 1'b1);
    in_beat_t b;
    b.symbol_index = sym;
    b.has_mid = mid;
    b.mid_ticks = px;
    b.time_stamp = ts == 0 ? {$urandom, $urandom} : ts;
    push_update(b);
  endtask

  // drop valid, wait out expected beats and any silent pair computation
  task automatic drain();
    int unsigned settle;
    settle = 2 * eff_count() * (54 * eff_window() + 300) + 200;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_signals.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_WINDOW_LENGTH: win_reg = val[6:0];
      CFG_SYMBOL_COUNT: cnt_reg = val[3:0];
      CFG_Z_THRESHOLD: thr_reg = val[23:0];
      CFG_ORDER_QUANTITY: qty_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned win, int unsigned cnt, int unsigned thr,
                           int unsigned qty);
    set_reg(CFG_WINDOW_LENGTH, CFG_DW'(win));
    set_reg(CFG_SYMBOL_COUNT, CFG_DW'(cnt));
    set_reg(CFG_Z_THRESHOLD, CFG_DW'(thr));
    set_reg(CFG_ORDER_QUANTITY, CFG_DW'(qty));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] next_price(int s);
    int unsigned mode;
    mode = $urandom_range(0, 19);
    case (mode)
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return base_px[s] * 3;
      4: return base_px[s] / 3;
      default: return base_px[s] + $urandom_range(0, base_px[s] / 32 + 1);
    endcase
  endfunction

  task automatic test_ignored_updates();
    tick(4'd3, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    tick(4'd8, 32'd77);
    tick(4'd15, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    configure(3, 0, 32768, 5);
    tick(4'd0, 32'd10);
    drain();
  endtask

  task automatic test_pair_cases();
    configure(3, 3, 32768, 65535);
    repeat (3) tick(4'd0, 32'd100);
    repeat (3) tick(4'd1, 32'd100);
    tick(4'd2, 32'd0);
    tick(4'd2, 32'd0);
    tick(4'd0, 32'd400, 64'hFFFF_FFFF_FFFF_FFFF);
    tick(4'd1, 32'hFFFF_FFFF, 64'd1);
    tick(4'd2, 32'd0);
    tick(4'd1, 32'd0);
    tick(4'd5, 32'd100);
    drain();
    configure(1, 3, 1, 1);
    tick(4'd0, 32'd900);
    tick(4'd1, 32'd3);
    drain();
    configure(3, 3, 0, 4660);
    tick(4'd0, 32'd50);
    tick(4'd1, 32'd70000);
    tick(4'd0, 32'd1);
    drain();
  endtask

  task automatic run_phase(int unsigned win, int unsigned cnt, int unsigned thr,
                           int unsigned qty, int items);
    int unsigned lim;
    configure(win, cnt, thr, qty);
    lim = eff_count() == 0 ? 1 : eff_count();
    for (int s = 0; s < NSYM; s++)
      base_px[s] = $urandom_range(0, 3) == 0 ? $urandom_range(1, 32'h7FFF_FFFF)
                                              : $urandom_range(1000, 2_000_000);
    for (int i = 0; i < items; i++) begin
      if (i == items / 2 && $urandom_range(0, 1) == 0) drain();
      if ($urandom_range(0, 9) == 0)
        tick(4'($urandom_range(0, 15)), $urandom, 64'd0, 1'($urandom_range(0, 1)));
      else
        tick(4'(lim - 1 - (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, lim - 1))),
             next_price(int'($urandom_range(0, lim - 1))));
    end
    drain();
  endtask

  task automatic test_random_settings();
    run_phase(4, 4, 16384, $urandom_range(0, 65535), 60);
    run_phase(2, 15, 32768, 65535, 50);
    run_phase(5, 5, 24576, 0, 50);
    run_phase(3, 8, 1, $urandom_range(0, 65535), 40);
    run_phase(6, 4, 24'hFF_FFFF, $urandom_range(0, 65535), 30);
    run_phase(8, 3, 65536, $urandom_range(0, 65535), 50);
    run_phase(127, 2, 8192, $urandom_range(0, 65535), 80);
  endtask

  task automatic test_no_backpressure();
    idle_on = 1'b0;
    stall_on = 1'b0;
    run_phase(3, 3, 20000, $urandom_range(0, 65535), 40);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ignored_updates();
    test_pair_cases();
    test_random_settings();
    test_no_backpressure();
    $display("Sent %0d updates (%0d ignored); checked %0d signal beats", updates_sent,
             updates_ignored, signals_seen);
    $display("over window, symbol count, threshold and quantity settings incl. extremes.");
    if (errors == 0 && pending_signals.size() == 0) begin
      $display("tb_pair_ratio_zscore_signal_unit: clean");
    end else begin
      $display("tb_pair_ratio_zscore_signal_unit: errors");
    end
    $finish;
  end

endmodule
